// ----- sv/sr_pkg.sv -----
// Shared types, widths and codes of the selective-repeat sender.
package sr_pkg;

   localparam int SEQ_W = 32;
   localparam int LEN_W = 11;
   localparam int TAG_W = 8;
   localparam int OP_W = 2;
   localparam int WSIZE_W = 4;

   localparam int WINDOW_MAX_DEF = 8;
   localparam int PENDING_DEPTH_DEF = 16;
   localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RESET = 4'd4;

   // Request opcodes as they arrive on the port
   localparam logic [OP_W-1:0] OP_SEND = 2'd0;
   localparam logic [OP_W-1:0] OP_REPLY = 2'd1;
   localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

   // Command kinds after classification
   localparam logic [1:0] KIND_SEND = 2'd0;
   localparam logic [1:0] KIND_ACK = 2'd1;
   localparam logic [1:0] KIND_NAK = 2'd2;
   localparam logic [1:0] KIND_TIMEOUT = 2'd3;

   typedef struct packed {
      logic [SEQ_W-1:0] seq;
      logic [LEN_W-1:0] length;
      logic [TAG_W-1:0] tag;
   } desc_type;

   typedef struct packed {
      logic [1:0] kind;
      desc_type frame;
      logic [SEQ_W-1:0] ref_seq;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ----- sv/sr_front.sv -----
// Front end: takes request words and classifies them into commands.
module sr_front (
   input  logic start,
   output logic busy,
   input  logic [sr_pkg::OP_W-1:0] req_op,
   input  logic [sr_pkg::SEQ_W-1:0] req_frame_seq,
   input  logic [sr_pkg::LEN_W-1:0] req_frame_length,
   input  logic [sr_pkg::TAG_W-1:0] req_buffer_tag,
   input  logic req_reply_is_nak,
   input  logic [sr_pkg::SEQ_W-1:0] req_ref_seq,
   input  sr_pkg::queue_status_type q_status,
   output logic push,
   output sr_pkg::cmd_type push_cmd
);

   logic known_op;

   // Hold off new words while the command queue is full
   assign busy = q_status.full;

   // Map opcode to command kind; drop the unused opcode
   always_comb begin
      known_op = 1'b1;
      push_cmd.kind = sr_pkg::KIND_SEND;
      case (req_op)
         sr_pkg::OP_SEND: begin
            push_cmd.kind = sr_pkg::KIND_SEND;
         end
         sr_pkg::OP_REPLY: begin
            push_cmd.kind = req_reply_is_nak ? sr_pkg::KIND_NAK : sr_pkg::KIND_ACK;
         end
         sr_pkg::OP_TIMEOUT: begin
            push_cmd.kind = sr_pkg::KIND_TIMEOUT;
         end
         default: begin
            known_op = 1'b0;
         end
      endcase
      push_cmd.frame.seq = req_frame_seq;
      push_cmd.frame.length = req_frame_length;
      push_cmd.frame.tag = req_buffer_tag;
      push_cmd.ref_seq = req_ref_seq;
   end

   assign push = start && !q_status.full && known_op;

endmodule

// ----- sv/sr_queue.sv -----
// Two-entry command queue between the front end and the engine.
module sr_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  sr_pkg::cmd_type push_cmd,
   input  logic pop,
   output sr_pkg::cmd_type head_cmd,
   output sr_pkg::queue_status_type q_status
);

   sr_pkg::cmd_type entry_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign q_status.full = (count_ff == 2'd2);
   assign q_status.empty = (count_ff == 2'd0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   assign do_push = push && !q_status.full;
   assign do_pop = pop && !q_status.empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- sv/sr_back.sv -----
// Engine: pending FIFO, in-flight window, search and refill sequencing.
module sr_back #(
   parameter int WINDOW_MAX = sr_pkg::WINDOW_MAX_DEF,
   parameter int PENDING_DEPTH = sr_pkg::PENDING_DEPTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [sr_pkg::WSIZE_W-1:0] csr_window_size,
   input  sr_pkg::queue_status_type q_status,
   input  sr_pkg::cmd_type head_cmd,
   output logic pop,
   output logic rsp_strobe,
   output logic [sr_pkg::SEQ_W-1:0] rsp_out_seq,
   output logic [sr_pkg::LEN_W-1:0] rsp_out_length,
   output logic [sr_pkg::TAG_W-1:0] rsp_out_tag,
   output logic rsp_is_retransmit,
   output logic rsp_dropped,
   output logic rsp_last
);

   localparam int WIDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int WCNT_W = $clog2(WINDOW_MAX + 1);
   localparam int WSUM_W = WIDX_W + 1;
   localparam int PIDX_W = $clog2(PENDING_DEPTH);
   localparam int PCNT_W = $clog2(PENDING_DEPTH + 1);
   localparam int PSUM_W = PIDX_W + 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DISPATCH = 3'd1;
   localparam logic [2:0] ST_SEARCH = 3'd2;
   localparam logic [2:0] ST_REFILL_CHK = 3'd3;
   localparam logic [2:0] ST_REFILL_WR = 3'd4;

   logic [2:0] state_ff, state_in;
   sr_pkg::cmd_type cmd_ff, cmd_in;
   logic [WCNT_W-1:0] idx_ff, idx_in;
   logic [PIDX_W-1:0] phead_ff, phead_in;
   logic [PCNT_W-1:0] pcount_ff, pcount_in;
   logic [WIDX_W-1:0] whead_ff, whead_in;
   logic [WCNT_W-1:0] wcount_ff, wcount_in;
   logic [sr_pkg::WSIZE_W-1:0] wsize_ff;

   sr_pkg::desc_type pend_mem [PENDING_DEPTH];
   sr_pkg::desc_type rd_data_ff;
   sr_pkg::desc_type window_ff [WINDOW_MAX];

   logic rsp_strobe_ff;
   sr_pkg::desc_type rsp_desc_ff;
   logic rsp_retx_ff, rsp_drop_ff, rsp_last_ff;

   logic emit, emit_retx, emit_drop, emit_last;
   sr_pkg::desc_type emit_desc;
   logic mem_we, mem_re, win_we;

   logic [31:0] eff_wide;
   logic [WCNT_W-1:0] eff_win;
   logic room;
   logic [WCNT_W-1:0] slot_off;
   logic [WSUM_W-1:0] slot_sum, retire_sum;
   logic [WIDX_W-1:0] slot, retire_head;
   logic [PSUM_W-1:0] tail_sum;
   logic [PIDX_W-1:0] ptail;
   logic [WCNT_W-1:0] wcount_nx;
   sr_pkg::desc_type win_rd;

   assign csr_ready = 1'b1;

   // Saturate the window size into one through the window depth
   always_comb begin
      if (wsize_ff == '0) begin
         eff_wide = 32'd1;
      end else if (32'(wsize_ff) > WINDOW_MAX) begin
         eff_wide = 32'(WINDOW_MAX);
      end else begin
         eff_wide = 32'(wsize_ff);
      end
   end
   assign eff_win = eff_wide[WCNT_W-1:0];
   assign room = (wcount_ff < eff_win);

   // Window slot: head plus search index or plus occupancy, wrapped once
   assign slot_off = (state_ff == ST_SEARCH) ? idx_ff : wcount_ff;
   assign slot_sum = WSUM_W'(whead_ff) + WSUM_W'(slot_off);
   assign slot = (slot_sum >= WSUM_W'(WINDOW_MAX)) ?
                 WIDX_W'(slot_sum - WSUM_W'(WINDOW_MAX)) : WIDX_W'(slot_sum);
   assign win_rd = window_ff[slot];

   // New head after a cumulative ack through the matched entry
   assign retire_sum = WSUM_W'(whead_ff) + WSUM_W'(idx_ff) + WSUM_W'(1);
   assign retire_head = (retire_sum >= WSUM_W'(WINDOW_MAX)) ?
                        WIDX_W'(retire_sum - WSUM_W'(WINDOW_MAX)) : WIDX_W'(retire_sum);

   // Pending tail slot
   assign tail_sum = PSUM_W'(phead_ff) + PSUM_W'(pcount_ff);
   assign ptail = (tail_sum >= PSUM_W'(PENDING_DEPTH)) ?
                  PIDX_W'(tail_sum - PSUM_W'(PENDING_DEPTH)) : PIDX_W'(tail_sum);

   assign wcount_nx = wcount_ff + WCNT_W'(1);

   // Sequence one command
   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      idx_in = idx_ff;
      phead_in = phead_ff;
      pcount_in = pcount_ff;
      whead_in = whead_ff;
      wcount_in = wcount_ff;
      pop = 1'b0;
      emit = 1'b0;
      emit_desc = cmd_ff.frame;
      emit_retx = 1'b0;
      emit_drop = 1'b0;
      emit_last = 1'b1;
      mem_we = 1'b0;
      mem_re = 1'b0;
      win_we = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop = 1'b1;
               cmd_in = head_cmd;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            idx_in = '0;
            if (cmd_ff.kind == sr_pkg::KIND_SEND) begin
               if (pcount_ff == PCNT_W'(PENDING_DEPTH)) begin
                  // Drop the frame and echo it back
                  emit = 1'b1;
                  emit_drop = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  mem_we = 1'b1;
                  pcount_in = pcount_ff + PCNT_W'(1);
                  state_in = room ? ST_REFILL_CHK : ST_IDLE;
               end
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (idx_ff == wcount_ff) begin
               // No entry matches
               state_in = (cmd_ff.kind == sr_pkg::KIND_TIMEOUT) ? ST_IDLE : ST_REFILL_CHK;
            end else if (win_rd.seq == cmd_ff.ref_seq) begin
               case (cmd_ff.kind)
                  sr_pkg::KIND_ACK: begin
                     whead_in = retire_head;
                     wcount_in = wcount_ff - (idx_ff + WCNT_W'(1));
                     state_in = ST_REFILL_CHK;
                  end
                  sr_pkg::KIND_NAK: begin
                     emit = 1'b1;
                     emit_desc = win_rd;
                     emit_retx = 1'b1;
                     emit_last = !(room && pcount_ff != '0);
                     state_in = ST_REFILL_CHK;
                  end
                  default: begin
                     emit = 1'b1;
                     emit_desc = win_rd;
                     emit_retx = 1'b1;
                     state_in = ST_IDLE;
                  end
               endcase
            end else begin
               idx_in = idx_ff + WCNT_W'(1);
            end
         end
         ST_REFILL_CHK: begin
            if (room && pcount_ff != '0) begin
               // Read the oldest pending frame
               mem_re = 1'b1;
               phead_in = (phead_ff == PIDX_W'(PENDING_DEPTH - 1)) ?
                          '0 : phead_ff + PIDX_W'(1);
               pcount_in = pcount_ff - PCNT_W'(1);
               state_in = ST_REFILL_WR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_REFILL_WR: begin
            // Move it into the window and transmit
            win_we = 1'b1;
            wcount_in = wcount_nx;
            emit = 1'b1;
            emit_desc = rd_data_ff;
            emit_last = (cmd_ff.kind == sr_pkg::KIND_SEND) ||
                        !(wcount_nx < eff_win && pcount_ff != '0);
            state_in = emit_last ? ST_IDLE : ST_REFILL_CHK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phead_ff <= '0;
         pcount_ff <= '0;
         whead_ff <= '0;
         wcount_ff <= '0;
         wsize_ff <= sr_pkg::WINDOW_SIZE_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phead_ff <= phead_in;
         pcount_ff <= pcount_in;
         whead_ff <= whead_in;
         wcount_ff <= wcount_in;
         rsp_strobe_ff <= emit;
         if (csr_valid && csr_ready) begin
            wsize_ff <= csr_window_size;
         end
      end
   end

   // Hold the command and the search index
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
   end

   // Pending memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pend_mem[ptail] <= cmd_ff.frame;
      end
      if (mem_re) begin
         rd_data_ff <= pend_mem[phead_ff];
      end
   end

   // Window entries
   always_ff @(posedge clock) begin
      if (win_we) begin
         window_ff[slot] <= rd_data_ff;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_desc_ff <= emit_desc;
         rsp_retx_ff <= emit_retx;
         rsp_drop_ff <= emit_drop;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_out_seq = rsp_desc_ff.seq;
   assign rsp_out_length = rsp_desc_ff.length;
   assign rsp_out_tag = rsp_desc_ff.tag;
   assign rsp_is_retransmit = rsp_retx_ff;
   assign rsp_dropped = rsp_drop_ff;
   assign rsp_last = rsp_last_ff;

endmodule

// ----- sv/selective_repeat_sender_top.sv -----
// Top level of the selective-repeat sender: front end, command queue, engine.
//
// Commands enter when start is high and busy is low; a two-word queue lets a
// new word be taken while the engine still works. Results leave one word per
// strobe cycle, with no backpressure, and rsp_last marks the final word of a
// command. The engine takes a command in its idle state and decodes it in the
// dispatch state, which also drops or queues a send; a send that moves a frame
// into the window then passes through the refill check and write states. Ack,
// nak and timeout walk the window one entry per cycle until a match or the end
// of the occupied entries, and each frame refilled after an ack or nak takes a
// pending memory read, then a window write. csr_window_size is taken at any
// cycle but should only change while no command is in progress.
module selective_repeat_sender_top #(
   parameter int WINDOW_MAX = sr_pkg::WINDOW_MAX_DEF,
   parameter int PENDING_DEPTH = sr_pkg::PENDING_DEPTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [sr_pkg::OP_W-1:0] req_op,
   input  logic [sr_pkg::SEQ_W-1:0] req_frame_seq,
   input  logic [sr_pkg::LEN_W-1:0] req_frame_length,
   input  logic [sr_pkg::TAG_W-1:0] req_buffer_tag,
   input  logic req_reply_is_nak,
   input  logic [sr_pkg::SEQ_W-1:0] req_ref_seq,
   output logic rsp_strobe,
   output logic [sr_pkg::SEQ_W-1:0] rsp_out_seq,
   output logic [sr_pkg::LEN_W-1:0] rsp_out_length,
   output logic [sr_pkg::TAG_W-1:0] rsp_out_tag,
   output logic rsp_is_retransmit,
   output logic rsp_dropped,
   output logic rsp_last,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [sr_pkg::WSIZE_W-1:0] csr_window_size
);

   sr_pkg::queue_status_type q_status;
   sr_pkg::cmd_type push_cmd;
   sr_pkg::cmd_type head_cmd;
   logic push;
   logic pop;

   sr_front u_front (
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_frame_seq(req_frame_seq),
      .req_frame_length(req_frame_length),
      .req_buffer_tag(req_buffer_tag),
      .req_reply_is_nak(req_reply_is_nak),
      .req_ref_seq(req_ref_seq),
      .q_status(q_status),
      .push(push),
      .push_cmd(push_cmd)
   );

   sr_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_cmd(push_cmd),
      .pop(pop),
      .head_cmd(head_cmd),
      .q_status(q_status)
   );

   sr_back #(
      .WINDOW_MAX(WINDOW_MAX),
      .PENDING_DEPTH(PENDING_DEPTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_window_size(csr_window_size),
      .q_status(q_status),
      .head_cmd(head_cmd),
      .pop(pop),
      .rsp_strobe(rsp_strobe),
      .rsp_out_seq(rsp_out_seq),
      .rsp_out_length(rsp_out_length),
      .rsp_out_tag(rsp_out_tag),
      .rsp_is_retransmit(rsp_is_retransmit),
      .rsp_dropped(rsp_dropped),
      .rsp_last(rsp_last)
   );

endmodule

// ----- test/tb_top.sv -----
// Testbench for the selective-repeat sender: directed and random commands checked against a predictor.
module tb_top;

   localparam logic [sr_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 64;
   localparam int PHASE_ITEMS = 48;

   typedef struct {
      sr_pkg::desc_type frame;
      bit retx;
      bit drop;
      bit last;
   } frame_word_type;

   // Track pending FIFO and in-flight window; hold the words the block must emit
   class arq_tracker;
      sr_pkg::desc_type fifo_ring [sr_pkg::PENDING_DEPTH_DEF];
      int fifo_head;
      int fifo_count;
      sr_pkg::desc_type win_ring [sr_pkg::WINDOW_MAX_DEF];
      int win_head;
      int win_count;
      logic [sr_pkg::WSIZE_W-1:0] window_size;
      frame_word_type expected_words [$];
      int errors;

      function void clear();
         fifo_head = 0;
         fifo_count = 0;
         win_head = 0;
         win_count = 0;
         window_size = sr_pkg::WINDOW_SIZE_RESET;
         expected_words.delete();
         errors = 0;
      endfunction

      function void set_window(logic [sr_pkg::WSIZE_W-1:0] value);
         window_size = value;
      endfunction

      function int window_limit();
         if (window_size == 0) return 1;
         if (window_size > sr_pkg::WINDOW_MAX_DEF) return sr_pkg::WINDOW_MAX_DEF;
         return window_size;
      endfunction

      function int outstanding();
         return expected_words.size();
      endfunction

      function void push_word(sr_pkg::desc_type d, bit retx, bit drop);
         frame_word_type w;
         w.frame = d;
         w.retx = retx;
         w.drop = drop;
         w.last = 1'b0;
         expected_words = {expected_words, w};
      endfunction

      // Move the oldest pending frame into the window and transmit it
      function void move_oldest();
         sr_pkg::desc_type d;
         d = fifo_ring[fifo_head];
         fifo_head = (fifo_head + 1) % sr_pkg::PENDING_DEPTH_DEF;
         fifo_count--;
         win_ring[(win_head + win_count) % sr_pkg::WINDOW_MAX_DEF] = d;
         win_count++;
         push_word(d, 1'b0, 1'b0);
      endfunction

      function int find_seq(logic [sr_pkg::SEQ_W-1:0] s);
         for (int i = 0; i < win_count; i++) begin
            if (win_ring[(win_head + i) % sr_pkg::WINDOW_MAX_DEF].seq == s) return i;
         end
         return -1;
      endfunction

      // Replace s with the sequence of a random in-flight frame, if any
      function void pick_live_seq(inout logic [sr_pkg::SEQ_W-1:0] s);
         if (win_count > 0)
            s = win_ring[(win_head + $urandom_range(0, win_count - 1)) %
                         sr_pkg::WINDOW_MAX_DEF].seq;
      endfunction

      // Predict the words caused by one accepted command
      function void note_command(logic [sr_pkg::OP_W-1:0] op, sr_pkg::desc_type frame,
                                 bit is_nak, logic [sr_pkg::SEQ_W-1:0] ref_seq);
         int first;
         int pos;
         first = expected_words.size();
         case (op)
            sr_pkg::OP_SEND: begin
               if (fifo_count >= sr_pkg::PENDING_DEPTH_DEF) begin
                  push_word(frame, 1'b0, 1'b1);
               end else begin
                  fifo_ring[(fifo_head + fifo_count) % sr_pkg::PENDING_DEPTH_DEF] = frame;
                  fifo_count++;
                  if (win_count < window_limit()) move_oldest();
               end
            end
            sr_pkg::OP_REPLY: begin
               pos = find_seq(ref_seq);
               if (!is_nak) begin
                  if (pos >= 0) begin
                     win_head = (win_head + pos + 1) % sr_pkg::WINDOW_MAX_DEF;
                     win_count -= pos + 1;
                  end
               end else if (pos >= 0) begin
                  push_word(win_ring[(win_head + pos) % sr_pkg::WINDOW_MAX_DEF], 1'b1, 1'b0);
               end
               // Refill the window from the FIFO
               while (win_count < window_limit() && fifo_count > 0 &&
                      expected_words.size() - first < 8)
                  move_oldest();
            end
            sr_pkg::OP_TIMEOUT: begin
               pos = find_seq(ref_seq);
               if (pos >= 0)
                  push_word(win_ring[(win_head + pos) % sr_pkg::WINDOW_MAX_DEF], 1'b1, 1'b0);
            end
            default: begin
            end
         endcase
         if (expected_words.size() > first) expected_words[$].last = 1'b1;
      endfunction

      function void report(string field, longint unsigned exp_v, longint unsigned act_v);
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
      endfunction

      // Compare one emitted word with the oldest expectation
      function void check_word(logic [sr_pkg::SEQ_W-1:0] seq, logic [sr_pkg::LEN_W-1:0] length,
                               logic [sr_pkg::TAG_W-1:0] tag, logic retx, logic drop,
                               logic last);
         frame_word_type w;
         if (expected_words.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, actual seq %0h", $time, seq);
            return;
         end
         w = expected_words[0];
         expected_words.delete(0);
         if (seq !== w.frame.seq) report("out_seq", w.frame.seq, seq);
         if (length !== w.frame.length) report("out_length", w.frame.length, length);
         if (tag !== w.frame.tag) report("out_tag", w.frame.tag, tag);
         if (retx !== w.retx) report("is_retransmit", w.retx, retx);
         if (drop !== w.drop) report("dropped", w.drop, drop);
         if (last !== w.last) report("last", w.last, last);
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [sr_pkg::OP_W-1:0] req_op;
   logic [sr_pkg::SEQ_W-1:0] req_frame_seq;
   logic [sr_pkg::LEN_W-1:0] req_frame_length;
   logic [sr_pkg::TAG_W-1:0] req_buffer_tag;
   logic req_reply_is_nak;
   logic [sr_pkg::SEQ_W-1:0] req_ref_seq;
   logic rsp_strobe;
   logic [sr_pkg::SEQ_W-1:0] rsp_out_seq;
   logic [sr_pkg::LEN_W-1:0] rsp_out_length;
   logic [sr_pkg::TAG_W-1:0] rsp_out_tag;
   logic rsp_is_retransmit;
   logic rsp_dropped;
   logic rsp_last;
   logic csr_valid;
   logic csr_ready;
   logic [sr_pkg::WSIZE_W-1:0] csr_window_size;

   arq_tracker tracker;
   int cycle_count;
   bit no_gaps;

   selective_repeat_sender_top uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_frame_seq(req_frame_seq),
      .req_frame_length(req_frame_length),
      .req_buffer_tag(req_buffer_tag),
      .req_reply_is_nak(req_reply_is_nak),
      .req_ref_seq(req_ref_seq),
      .rsp_strobe(rsp_strobe),
      .rsp_out_seq(rsp_out_seq),
      .rsp_out_length(rsp_out_length),
      .rsp_out_tag(rsp_out_tag),
      .rsp_is_retransmit(rsp_is_retransmit),
      .rsp_dropped(rsp_dropped),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_window_size(csr_window_size)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Check every strobed word
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         tracker.check_word(rsp_out_seq, rsp_out_length, rsp_out_tag,
                            rsp_is_retransmit, rsp_dropped, rsp_last);
   end

   function automatic int idle_len();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Build a frame descriptor from random bits
   function automatic sr_pkg::desc_type random_desc();
      sr_pkg::desc_type d;
      logic [31:0] r_seq;
      logic [31:0] r_len;
      logic [31:0] r_tag;
      r_seq = $urandom;
      r_len = $urandom;
      r_tag = $urandom;
      d.seq = r_seq;
      d.length = r_len[sr_pkg::LEN_W-1:0];
      d.tag = r_tag[sr_pkg::TAG_W-1:0];
      return d;
   endfunction

   // Present one command word at a falling edge and hold it until taken
   task automatic issue(logic [sr_pkg::OP_W-1:0] op, sr_pkg::desc_type frame, bit is_nak,
                        logic [sr_pkg::SEQ_W-1:0] ref_seq);
      int gap;
      start <= 1'b1;
      req_op <= op;
      req_frame_seq <= frame.seq;
      req_frame_length <= frame.length;
      req_buffer_tag <= frame.tag;
      req_reply_is_nak <= is_nak;
      req_ref_seq <= ref_seq;
      @(posedge clock);
      while (busy) @(posedge clock);
      tracker.note_command(op, frame, is_nak, ref_seq);
      @(negedge clock);
      gap = idle_len();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_frame(logic [sr_pkg::SEQ_W-1:0] seq, logic [sr_pkg::LEN_W-1:0] length,
                             logic [sr_pkg::TAG_W-1:0] tag);
      sr_pkg::desc_type d;
      d.seq = seq;
      d.length = length;
      d.tag = tag;
      issue(sr_pkg::OP_SEND, d, 1'($urandom), $urandom);
   endtask

   task automatic other_cmd(logic [sr_pkg::OP_W-1:0] op, bit is_nak,
                            logic [sr_pkg::SEQ_W-1:0] ref_seq);
      sr_pkg::desc_type d;
      d = random_desc();
      issue(op, d, is_nak, ref_seq);
   endtask

   // Drop start and wait until every expected word is out and the engine settles
   task automatic quiesce();
      start <= 1'b0;
      while (tracker.outstanding() > 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_window(logic [sr_pkg::WSIZE_W-1:0] value);
      quiesce();
      csr_valid <= 1'b1;
      csr_window_size <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.set_window(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random command: sends, replies, timeouts and the unused opcode; most replies and timeouts hit in-flight frames
   task automatic random_item(int send_pct);
      sr_pkg::desc_type d;
      logic [sr_pkg::OP_W-1:0] op;
      logic [sr_pkg::SEQ_W-1:0] ref_seq;
      int r;
      d = random_desc();
      ref_seq = $urandom;
      r = $urandom_range(0, 99);
      if (r < send_pct) op = sr_pkg::OP_SEND;
      else if (r < send_pct + (100 - send_pct) * 6 / 10) op = sr_pkg::OP_REPLY;
      else if (r < 97) op = sr_pkg::OP_TIMEOUT;
      else op = OP_UNUSED;
      if (op != sr_pkg::OP_SEND && $urandom_range(0, 3) != 0) tracker.pick_live_seq(ref_seq);
      issue(op, d, 1'($urandom), ref_seq);
   endtask

   initial begin
      int win_plan [8];
      int mix [3];
      sr_pkg::desc_type rd;
      logic [31:0] plan_word;
      tracker = new();
      tracker.clear();
      cycle_count = 0;
      no_gaps = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_op = sr_pkg::OP_SEND;
      req_frame_seq = '0;
      req_frame_length = '0;
      req_buffer_tag = '0;
      req_reply_is_nak = 1'b0;
      req_ref_seq = '0;
      csr_valid = 1'b0;
      csr_window_size = '0;
      win_plan = '{1, 8, 3, 0, 15, 2, 5, 7};
      mix = '{35, 55, 75};
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Window of zero saturates to one; fill the FIFO and overflow it
      write_window(4'd0);
      send_frame(32'h0, 11'h0, 8'h0);
      send_frame(32'hFFFF_FFFF, 11'h7FF, 8'hFF);
      for (int i = 0; i < 15; i++) begin
         rd = random_desc();
         send_frame(32'h100 + i, rd.length, rd.tag);
      end
      rd = random_desc();
      send_frame(32'hDEAD_BEEF, rd.length, rd.tag);
      // Nak and timeout hits, misses, an ack miss and the unused opcode
      other_cmd(sr_pkg::OP_REPLY, 1'b1, 32'h0);
      other_cmd(sr_pkg::OP_TIMEOUT, 1'b0, 32'h0);
      other_cmd(sr_pkg::OP_TIMEOUT, 1'b1, 32'h0001_2345);
      other_cmd(sr_pkg::OP_REPLY, 1'b1, 32'hFFFF_FFFF);
      other_cmd(sr_pkg::OP_REPLY, 1'b0, 32'h5555);
      other_cmd(OP_UNUSED, 1'b0, 32'h0);
      other_cmd(sr_pkg::OP_REPLY, 1'b0, 32'h0);
      // Raise above the maximum: a send moves the oldest pending frame, an ack refills many
      write_window(4'd15);
      rd = random_desc();
      send_frame(rd.seq, rd.length, rd.tag);
      other_cmd(sr_pkg::OP_REPLY, 1'b0, 32'hFFFF_FFFF);

      // Random phases, starting with the window lowered under its occupancy
      for (int p = 0; p < 8; p++) begin
         if (p >= 5) win_plan[p] = $urandom_range(0, 15);
         plan_word = win_plan[p];
         write_window(plan_word[sr_pkg::WSIZE_W-1:0]);
         no_gaps = (p == 2 || p == 6);
         repeat (PHASE_ITEMS) random_item(mix[p % 3]);
      end
      no_gaps = 1'b0;

      quiesce();
      if (tracker.errors == 0 && tracker.outstanding() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
